/* sv/cell_pool_allocator_macros.svh */
// assertion macros for the cell pool allocator
// no dependencies; included by modules that carry assertions
`ifndef CELL_POOL_ALLOCATOR_MACROS_SVH
`define CELL_POOL_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define CPA_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`define CPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CPA_ASSERT(label, cond, msg)
`define CPA_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

/* sv/cpa_pkg.sv */
// shared constants, codes and types for the cell pool allocator
// no dependencies
`default_nettype none
package cpa_pkg;
  localparam int MaxBlocks        = 8;
  localparam int MaxCellsPerBlock = 256;
  localparam int PoolCells        = MaxBlocks * MaxCellsPerBlock;
  localparam int HandleW          = $clog2(PoolCells);
  localparam int LinkW            = HandleW + 1;
  localparam int PrevW            = LinkW + 1;
  localparam int BlkW             = $clog2(MaxBlocks);
  localparam int IdxW             = $clog2(MaxCellsPerBlock);
  localparam int CpbW             = $clog2(MaxCellsPerBlock + 1);
  localparam int BlkCntW          = $clog2(MaxBlocks + 1);
  localparam int CntW             = LinkW;
  localparam int TotW             = 32;
  localparam int CfgW             = 9;
  localparam int ActW             = 3;
  localparam int StW              = 2;
  localparam logic [LinkW-1:0] Nil = LinkW'(PoolCells);

  localparam logic [ActW-1:0] ActAlloc = 3'd0;
  localparam logic [ActW-1:0] ActFree  = 3'd1;
  localparam logic [ActW-1:0] ActFirst = 3'd2;
  localparam logic [ActW-1:0] ActNext  = 3'd3;
  localparam logic [ActW-1:0] ActClear = 3'd4;

  localparam logic [StW-1:0] StOk  = 2'd0;
  localparam logic [StW-1:0] StOom = 2'd1;
  localparam logic [StW-1:0] StBad = 2'd2;
  localparam logic [StW-1:0] StEnd = 2'd3;

  typedef struct packed {
    logic               we;
    logic [HandleW-1:0] waddr;
    logic [PrevW-1:0]   wdata;
    logic [HandleW-1:0] raddr;
  } prev_req_t;

  typedef struct packed {
    logic               we;
    logic [HandleW-1:0] waddr;
    logic [LinkW-1:0]   wdata;
    logic [HandleW-1:0] raddr;
  } next_req_t;

  typedef struct packed {
    logic [TotW-1:0]    free_tot;
    logic [TotW-1:0]    alloc_tot;
    logic [CntW-1:0]    peak;
    logic [CntW-1:0]    cur;
    logic [StW-1:0]     st;
    logic [HandleW-1:0] res;
  } result_t;

  function automatic logic [CpbW-1:0] eff_cpb(input logic [CfgW-1:0] v);
    logic [CpbW-1:0] r;
    if (v == '0) begin
      r = CpbW'(1);
    end else if (v > CfgW'(MaxCellsPerBlock)) begin
      r = CpbW'(MaxCellsPerBlock);
    end else begin
      r = CpbW'(v);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

/* sv/cpa_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module cpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* sv/cpa_ctrl.sv */
// request sequencer: list heads, counters and read-modify-write of the link rams
// depends on cpa_pkg and cell_pool_allocator_macros.svh
`default_nettype none
`include "cell_pool_allocator_macros.svh"
module cpa_ctrl import cpa_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ActW-1:0]    action_i,
  input  wire logic [HandleW-1:0] handle_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  output prev_req_t               prev_req_o,
  input  wire logic [PrevW-1:0]   prev_rdata_i,
  output next_req_t               next_req_o,
  input  wire logic [LinkW-1:0]   next_rdata_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output result_t                 res_o
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_A_RD = 4'd1;
  localparam logic [3:0] S_A_W1 = 4'd2;
  localparam logic [3:0] S_A_W2 = 4'd3;
  localparam logic [3:0] S_A_W3 = 4'd4;
  localparam logic [3:0] S_F_RD = 4'd5;
  localparam logic [3:0] S_F_W1 = 4'd6;
  localparam logic [3:0] S_F_W2 = 4'd7;
  localparam logic [3:0] S_F_W3 = 4'd8;
  localparam logic [3:0] S_N_RD = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0]         state_q, state_d;
  logic [CpbW-1:0]    cpb_q, cpb_d;
  logic [CpbW-1:0]    fresh_q, fresh_d;
  logic [BlkCntW-1:0] blocks_q, blocks_d;
  logic [LinkW-1:0]   free_head_q, free_head_d;
  logic [LinkW-1:0]   free_tail_q, free_tail_d;
  logic [LinkW-1:0]   inuse_q, inuse_d;
  logic [CntW-1:0]    live_q, live_d;
  logic [CntW-1:0]    high_q, high_d;
  logic [TotW-1:0]    alloc_q, alloc_d;
  logic [TotW-1:0]    free_q, free_d;
  logic [HandleW-1:0] h_q, h_d;
  logic [LinkW-1:0]   p_q, p_d;
  logic [LinkW-1:0]   n_q, n_d;
  logic [LinkW-1:0]   pfix_q, pfix_d;
  logic [HandleW-1:0] res_q, res_d;
  logic [StW-1:0]     st_q, st_d;

  logic [BlkW-1:0]    blk;
  logic [IdxW-1:0]    idx;
  logic [BlkW-1:0]    last_blk;
  logic               live_ok;
  logic               fresh_avail;
  logic               do_clear;
  logic [CpbW-1:0]    clear_cpb;
  logic [CntW-1:0]    live_inc;

  assign blk         = handle_i[HandleW-1:IdxW];
  assign idx         = handle_i[IdxW-1:0];
  assign last_blk    = BlkW'(blocks_q - BlkCntW'(1));
  assign fresh_avail = fresh_q < cpb_q;
  assign live_ok     = (BlkCntW'(blk) < blocks_q) && (CpbW'(idx) < cpb_q) &&
                       !((blk == last_blk) && (CpbW'(idx) >= fresh_q));
  assign live_inc    = live_q + CntW'(1);

  always_comb begin
    state_d     = state_q;
    cpb_d       = cpb_q;
    fresh_d     = fresh_q;
    blocks_d    = blocks_q;
    free_head_d = free_head_q;
    free_tail_d = free_tail_q;
    inuse_d     = inuse_q;
    live_d      = live_q;
    high_d      = high_q;
    alloc_d     = alloc_q;
    free_d      = free_q;
    h_d         = h_q;
    p_d         = p_q;
    n_d         = n_q;
    pfix_d      = pfix_q;
    res_d       = res_q;
    st_d        = st_q;
    prev_req_o  = '0;
    next_req_o  = '0;
    do_clear    = 1'b0;
    clear_cpb   = cpb_q;
    in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
    cfg_ready_o = (state_q == S_IDLE);
    res_valid_o = (state_q == S_OUT);

    unique case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) begin
          cpb_d     = eff_cpb(cfg_data_i);
          clear_cpb = eff_cpb(cfg_data_i);
          do_clear  = 1'b1;
        end else if (in_valid_i) begin
          h_d     = handle_i;
          res_d   = '0;
          st_d    = StOk;
          state_d = S_OUT;
          case (action_i)
            ActAlloc: begin
              if (fresh_avail) begin
                h_d     = {last_blk, fresh_q[IdxW-1:0]};
                fresh_d = fresh_q + CpbW'(1);
                pfix_d  = Nil;
                state_d = S_A_W1;
              end else if (free_head_q != Nil) begin
                next_req_o.raddr = free_head_q[HandleW-1:0];
                h_d              = free_head_q[HandleW-1:0];
                state_d          = S_A_RD;
              end else if (blocks_q < BlkCntW'(MaxBlocks)) begin
                blocks_d = blocks_q + BlkCntW'(1);
                h_d      = {blocks_q[BlkW-1:0], {IdxW{1'b0}}};
                fresh_d  = CpbW'(1);
                pfix_d   = Nil;
                state_d  = S_A_W1;
              end else begin
                st_d = StOom;
              end
            end
            ActFree, ActNext: begin
              if (!live_ok) begin
                st_d = StBad;
              end else begin
                prev_req_o.raddr = handle_i;
                next_req_o.raddr = handle_i;
                state_d = (action_i == ActFree) ? S_F_RD : S_N_RD;
              end
            end
            ActFirst: begin
              if (inuse_q == Nil) begin
                st_d = StEnd;
              end else begin
                res_d = inuse_q[HandleW-1:0];
              end
            end
            ActClear: begin
              do_clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_A_RD: begin
        free_head_d = next_rdata_i;
        if (next_rdata_i == Nil) begin
          free_tail_d = Nil;
        end
        pfix_d  = next_rdata_i;
        state_d = S_A_W1;
      end
      S_A_W1: begin
        prev_req_o.we    = 1'b1;
        prev_req_o.waddr = h_q;
        prev_req_o.wdata = {1'b1, Nil};
        next_req_o.we    = 1'b1;
        next_req_o.waddr = h_q;
        next_req_o.wdata = inuse_q;
        state_d          = S_A_W2;
      end
      S_A_W2: begin
        if (pfix_q != Nil) begin
          prev_req_o.we    = 1'b1;
          prev_req_o.waddr = pfix_q[HandleW-1:0];
          prev_req_o.wdata = {1'b0, Nil};
        end
        state_d = S_A_W3;
      end
      S_A_W3: begin
        if (inuse_q != Nil) begin
          prev_req_o.we    = 1'b1;
          prev_req_o.waddr = inuse_q[HandleW-1:0];
          prev_req_o.wdata = {1'b1, 1'b0, h_q};
        end
        inuse_d = {1'b0, h_q};
        live_d  = live_inc;
        alloc_d = alloc_q + TotW'(1);
        if (live_inc > high_q) begin
          high_d = live_inc;
        end
        res_d   = h_q;
        st_d    = StOk;
        state_d = S_OUT;
      end
      S_F_RD: begin
        if (!prev_rdata_i[LinkW]) begin
          st_d    = StBad;
          state_d = S_OUT;
        end else begin
          p_d     = prev_rdata_i[LinkW-1:0];
          n_d     = next_rdata_i;
          state_d = S_F_W1;
        end
      end
      S_F_W1: begin
        next_req_o.we    = 1'b1;
        next_req_o.waddr = h_q;
        next_req_o.wdata = Nil;
        prev_req_o.we    = 1'b1;
        prev_req_o.waddr = h_q;
        prev_req_o.wdata = {1'b0, free_tail_q};
        state_d          = S_F_W2;
      end
      S_F_W2: begin
        if (p_q != Nil) begin
          next_req_o.we    = 1'b1;
          next_req_o.waddr = p_q[HandleW-1:0];
          next_req_o.wdata = n_q;
        end else begin
          inuse_d = n_q;
        end
        if (n_q != Nil) begin
          prev_req_o.we    = 1'b1;
          prev_req_o.waddr = n_q[HandleW-1:0];
          prev_req_o.wdata = {1'b1, p_q};
        end
        state_d = S_F_W3;
      end
      S_F_W3: begin
        if (free_tail_q != Nil) begin
          next_req_o.we    = 1'b1;
          next_req_o.waddr = free_tail_q[HandleW-1:0];
          next_req_o.wdata = {1'b0, h_q};
        end else begin
          free_head_d = {1'b0, h_q};
        end
        free_tail_d = {1'b0, h_q};
        live_d      = live_q - CntW'(1);
        free_d      = free_q + TotW'(1);
        res_d       = '0;
        st_d        = StOk;
        state_d     = S_OUT;
      end
      S_N_RD: begin
        if (!prev_rdata_i[LinkW]) begin
          st_d = StBad;
        end else if (next_rdata_i == Nil) begin
          st_d = StEnd;
        end else begin
          res_d = next_rdata_i[HandleW-1:0];
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (do_clear) begin
      free_head_d = Nil;
      free_tail_d = Nil;
      inuse_d     = Nil;
      fresh_d     = clear_cpb;
      blocks_d    = '0;
      live_d      = '0;
      high_d      = '0;
      alloc_d     = '0;
      free_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cpb_q       <= CpbW'(MaxCellsPerBlock);
      fresh_q     <= CpbW'(MaxCellsPerBlock);
      blocks_q    <= '0;
      free_head_q <= Nil;
      free_tail_q <= Nil;
      inuse_q     <= Nil;
      live_q      <= '0;
      high_q      <= '0;
      alloc_q     <= '0;
      free_q      <= '0;
    end else begin
      state_q     <= state_d;
      cpb_q       <= cpb_d;
      fresh_q     <= fresh_d;
      blocks_q    <= blocks_d;
      free_head_q <= free_head_d;
      free_tail_q <= free_tail_d;
      inuse_q     <= inuse_d;
      live_q      <= live_d;
      high_q      <= high_d;
      alloc_q     <= alloc_d;
      free_q      <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    p_q    <= p_d;
    n_q    <= n_d;
    pfix_q <= pfix_d;
    res_q  <= res_d;
    st_q   <= st_d;
  end

  assign res_o = '{free_tot: free_q, alloc_tot: alloc_q, peak: high_q, cur: live_q,
                   st: st_q, res: res_q};

  `CPA_ASSERT(a_peak_ge_live, high_q >= live_q, "peak below current count")
  `CPA_ASSERT(a_fresh_bound, (fresh_q <= cpb_q) && (blocks_q <= BlkCntW'(MaxBlocks)),
    "fresh index or block count out of range")
  `CPA_ASSERT(a_free_lists, (free_head_q == Nil) == (free_tail_q == Nil),
    "free list head and tail disagree")
  `CPA_ASSERT_IMP(a_alloc_done, state_q == S_A_W3, (live_q != '0) && (inuse_q != Nil),
    "allocation left in-use list empty")
endmodule
`default_nettype wire

/* sv/cell_pool_allocator.sv */
// Cell pool allocator top level: link rams, sequencer and output register.
// depends on cpa_pkg, cpa_ram, cpa_ctrl
//
// A request enters on s_axis (action and handle in tdata); one result leaves
// on m_axis per request, carrying the handle, status and pool statistics.
// cells_per_block is written on the cfg channel; a write also clears the pool.
// Requests are handled one at a time. first, clear and rejected requests go
// straight to the result state; next and free first read the link rams (a
// free that names a cell not in use ends there), then free and alloc write them;
// the sequence is set by the read-modify-write of the prev and next link rams,
// each with one write port and a registered read.
// A finished result sits in the output register while the next request is
// accepted; if m_axis stalls, the sequencer holds its result until the
// register frees up and then takes new requests again.
// After reset the pool is empty and cells_per_block is 256. The link rams
// need no clearing pass: an entry is always written before it is read.
`default_nettype none
module cell_pool_allocator import cpa_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [15:0]  s_axis_tdata,  // action, handle
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [103:0] m_axis_tdata,  // result_handle, status, current_count,
                                           // peak_count, alloc_total, free_total
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [CfgW-1:0] cfg_data_i
);
  prev_req_t            prev_req;
  next_req_t            next_req;
  logic [PrevW-1:0]     prev_rdata;
  logic [LinkW-1:0]     next_rdata;
  logic                 res_valid;
  logic                 out_free;
  result_t              res;
  logic                 ovalid_q;
  result_t              odata_q;

  cpa_ram #(.Width(PrevW), .Depth(PoolCells)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_req.we),
    .waddr_i (prev_req.waddr),
    .wdata_i (prev_req.wdata),
    .raddr_i (prev_req.raddr),
    .rdata_o (prev_rdata)
  );

  cpa_ram #(.Width(LinkW), .Depth(PoolCells)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_req.we),
    .waddr_i (next_req.waddr),
    .wdata_i (next_req.wdata),
    .raddr_i (next_req.raddr),
    .rdata_o (next_rdata)
  );

  cpa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .action_i     (s_axis_tdata[ActW-1:0]),
    .handle_i     (s_axis_tdata[ActW+HandleW-1:ActW]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .prev_req_o   (prev_req),
    .prev_rdata_i (prev_rdata),
    .next_req_o   (next_req),
    .next_rdata_i (next_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (out_free),
    .res_o        (res)
  );

  assign out_free = !ovalid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (res_valid && out_free) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      odata_q <= res;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'b000, odata_q};
endmodule
`default_nettype wire
